[rtl/dwds_pkg.sv]
// shared types and constants of the wildcard directory search
package dwds_pkg;

    localparam int unsigned ENTRIES_DEF = 256;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] ATTR_HID  = 8'h02;
    localparam logic [7:0] ATTR_PROT = 8'h04;
    localparam logic [7:0] ATTR_VOL  = 8'h08;
    localparam logic [7:0] ATTR_DIR  = 8'h10;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] entry_name;
        logic [23:0] entry_ext;
        logic [7:0]  entry_attrs;
        logic [31:0] entry_size;
        logic [31:0] entry_time;
        logic [63:0] mask_name;
        logic [23:0] mask_ext;
        logic [7:0]  search_attr;
        logic [8:0]  start_index;
        logic        root_dir;
    } t_in;

    typedef struct packed {
        logic        found;
        logic [8:0]  resume_index;
        logic [63:0] found_name;
        logic [23:0] found_ext;
        logic [7:0]  found_attrs;
        logic [31:0] found_size;
        logic [31:0] found_time;
        logic        append_dropped;
    } t_out;

    // one stored directory entry
    typedef struct packed {
        logic [63:0] name;
        logic [23:0] ext;
        logic [7:0]  attrs;
        logic [31:0] size;
        logic [31:0] time_stamp;
    } t_ent;

    // search key compared against the entry in the head cell
    typedef struct packed {
        logic [63:0] mask_name;
        logic [23:0] mask_ext;
        logic [7:0]  attr;
        logic        root;
    } t_key;

    function automatic logic [7:0] up_byte(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A) r = c - 8'h20;
        return r;
    endfunction

endpackage

[rtl/dos_wildcard_directory_search.sv]
// top level: directory table held in a rotating row of cells, searched at the head
//
//  channel | signals                         | beat
//  in      | i_valid o_in_ready i_data       | one request: clear, append, search or none
//  out     | o_valid i_out_ready o_data      | one result per request
//
// clear and append return their result beat directly, without a scan
// a search rotates the whole row once, checking the head cell
// each cycle; the full rotation restores the original order
// reset empties the table at once; a stalled output holds the next request off
module dos_wildcard_directory_search
    import dwds_pkg::*;
#(
    parameter int unsigned ENTRIES = ENTRIES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_in_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_out_ready,
    output t_out o_data
);
    localparam int unsigned IW = $clog2(ENTRIES + 1);
    localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic [IW-1:0] r_count, n_count;
    logic [IW-1:0] r_pos, n_pos;
    logic [IW-1:0] r_start;
    logic          r_done, n_done;
    t_key          r_key;
    logic          r_ov, n_ov;
    t_out          r_out, n_out;

    t_ent cell_ent [ENTRIES];
    logic shift_en;
    logic head_hit;
    logic accept;
    t_ent load_ent;

    assign accept     = i_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE) && !r_ov;
    assign shift_en   = (r_state == ST_SCAN);
    assign load_ent   = '{name: i_data.entry_name, ext: i_data.entry_ext,
                          attrs: i_data.entry_attrs, size: i_data.entry_size,
                          time_stamp: i_data.entry_time};

    // row of cells, rotating toward cell 0 during a search
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        dwds_cell u_cell (
            .i_clk      (i_clk),
            .i_load     (accept && i_data.req_type == REQ_APPEND &&
                         r_count < IW'(ENTRIES) && r_count[AW-1:0] == AW'(g)),
            .i_shift    (shift_en),
            .i_load_ent (load_ent),
            .i_next_ent (cell_ent[(g + 1) % ENTRIES]),
            .o_ent      (cell_ent[g])
        );
    end

    dwds_match u_match (
        .i_ent (cell_ent[0]),
        .i_key (r_key),
        .o_hit (head_hit)
    );

    // request decode and scan control
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_pos   = r_pos;
        n_done  = r_done;
        n_ov    = r_ov;
        n_out   = r_out;
        if (o_valid && i_out_ready) n_ov = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_out = '0;
                    unique case (t_req'(i_data.req_type))
                        REQ_CLEAR: begin
                            n_count = '0;
                            n_ov = 1'b1;
                        end
                        REQ_APPEND: begin
                            if (r_count >= IW'(ENTRIES)) n_out.append_dropped = 1'b1;
                            else n_count = r_count + 1'b1;
                            n_ov = 1'b1;
                        end
                        REQ_SEARCH: begin
                            n_pos   = '0;
                            n_done  = 1'b0;
                            n_state = ST_SCAN;
                        end
                        REQ_NONE: n_ov = 1'b1;
                        default: n_ov = 1'b1;
                    endcase
                end
            end
            ST_SCAN: begin
                if (!r_done && r_pos >= r_start && r_pos < r_count && head_hit) begin
                    n_done = 1'b1;
                    n_out.found = 1'b1;
                    n_out.resume_index = 9'(r_pos + 1'b1);
                    n_out.found_name  = cell_ent[0].name;
                    n_out.found_ext   = cell_ent[0].ext;
                    n_out.found_attrs = cell_ent[0].attrs;
                    n_out.found_size  = cell_ent[0].size;
                    n_out.found_time  = cell_ent[0].time_stamp;
                end
                n_pos = r_pos + 1'b1;
                if (r_pos == IW'(ENTRIES - 1)) begin
                    n_state = ST_IDLE;
                    n_ov = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    // search key and result payload
    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_done <= n_done;
        r_out  <= n_out;
        if (accept) begin
            r_start <= (i_data.start_index > 9'(ENTRIES)) ? IW'(ENTRIES)
                                                          : IW'(i_data.start_index);
            r_key   <= '{mask_name: i_data.mask_name, mask_ext: i_data.mask_ext,
                         attr: i_data.search_attr, root: i_data.root_dir};
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;
endmodule

[rtl/dwds_cell.sv]
// one cell of the entry row: holds an entry, shifts entries toward the head
module dwds_cell
    import dwds_pkg::*;
(
    input  logic i_clk,
    input  logic i_load,
    input  logic i_shift,
    input  t_ent i_load_ent,
    input  t_ent i_next_ent,
    output t_ent o_ent
);
    t_ent r_ent;
    t_ent n_ent;

    // load from the append port or take the neighbor's entry during a rotate
    always_comb begin
        n_ent = r_ent;
        if (i_shift) n_ent = i_next_ent;
        else if (i_load) n_ent = i_load_ent;
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_ent = r_ent;
endmodule

[rtl/dwds_match.sv]
// compare of the head entry against the search key
module dwds_match
    import dwds_pkg::*;
(
    input  t_ent i_ent,
    input  t_key i_key,
    output logic o_hit
);
    logic name_ok;
    logic attr_ok;
    logic [87:0] m;
    logic [87:0] v;

    always_comb begin
        m = {i_key.mask_ext, i_key.mask_name};
        v = {i_ent.ext, i_ent.name};
        name_ok = 1'b1;
        for (int b = 0; b < 11; b++) begin
            if (m[8*b +: 8] != CH_QMARK &&
                up_byte(m[8*b +: 8]) != up_byte(v[8*b +: 8])) name_ok = 1'b0;
        end
        if (i_key.attr == ATTR_VOL) attr_ok = (i_ent.attrs & ATTR_VOL) != 8'h00;
        else attr_ok = ((i_key.attr | (i_ent.attrs & (ATTR_HID | ATTR_PROT | ATTR_DIR)))
                       == i_key.attr);
        o_hit = name_ok && attr_ok && !(i_key.root && i_ent.name[7:0] == CH_DOT);
    end
endmodule
